[hw/rtl/tarh_pkg.sv]
// Shared types and fixed constants for the task arrival release heap.
// No dependencies; used by task_arrival_release_heap.

package tarh_pkg;

  // Field widths of one beat
  localparam int unsigned TimeW   = 16;
  localparam int unsigned IdW     = 5;
  localparam int unsigned TickW   = 32;
  localparam int unsigned QCountW = 5;

  // Tasks with an id at or above this count are ignored
  localparam int unsigned TASK_COUNT = 32;
  localparam int unsigned TaskCntW   = 9;

  // Ticks per time unit; due when tick >= arrival * TICKS_PER_UNIT
  localparam int unsigned TICKS_PER_UNIT = 100;
  localparam int unsigned TpuW  = $clog2(TICKS_PER_UNIT + 1);
  localparam int unsigned ProdW = TimeW + TpuW;
  localparam int unsigned CmpW  = (ProdW > TickW) ? ProdW : TickW;

  // Beat packing
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 16;

  // One heap slot: arrival time and task id
  typedef struct packed {
    logic [TimeW-1:0] arr;
    logic [IdW-1:0]   id;
  } heap_entry_t;

  // Input operation codes
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_TK_MUL,
    ST_TK_CMP,
    ST_TK_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_WR_FIN,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/task_arrival_release_heap.sv]
// Task arrival release heap: min-heap of pending tasks keyed on arrival time.
// Depends on tarh_pkg.
//
// Usage: one input beat on the s_axis channel per command. tuser selects an
// add (0) or a timer tick (1). An add with arrival time zero starts its task
// at once; otherwise the task is pushed and sifted up, or rejected if the
// heap is full. A tick pops the top task when current_tick / TICKS_PER_UNIT
// reaches its arrival time and sifts the moved entry down; every input beat
// yields one result beat on m_axis.
// Sequence: an add that starts, is dropped or is rejected and a tick on an
// empty heap go straight to the result; a tick reads the top, forms
// arrival * TICKS_PER_UNIT and compares it with the tick; a push reads and
// compares the parent at each level it climbs; a pop fetches the last entry
// and walks the heap RAM down level by level, reading the left child and,
// where one exists, the right, picking the earlier and comparing, then
// writes the moved entry to its slot. The heap RAM has one read and one write
// port. Input is taken only while the sequencer is idle, so a beat is not taken until the last result is loaded.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and runs until its own result is ready. Reset
// empties the heap and drops any pending result; heap RAM is not cleared.

module task_arrival_release_heap #(
  parameter int unsigned HEAP_CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: task_id[4:0], arrival_time[20:5], current_tick[52:21], zero pad
  input  logic [tarh_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: operation[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: started[0], started_task_id[5:1], rejected_full[6],
  //        queued_count[11:7], zero pad
  output logic [tarh_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned CntW  = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned SlotW = CntW + 1;
  localparam int unsigned AddrW = $clog2(HEAP_CAPACITY);

  // Input field split
  logic [tarh_pkg::IdW-1:0]   in_id;
  logic [tarh_pkg::TimeW-1:0] in_arr;
  logic [tarh_pkg::TickW-1:0] in_tick;
  tarh_pkg::op_e              in_op;

  assign in_id   = s_axis_tdata_i[4:0];
  assign in_arr  = s_axis_tdata_i[20:5];
  assign in_tick = s_axis_tdata_i[52:21];
  assign in_op   = tarh_pkg::op_e'(s_axis_tuser_i);

  // Registers
  tarh_pkg::state_e           state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [SlotW-1:0]           k_q, k_d;
  logic [SlotW-1:0]           j_q, j_d;
  tarh_pkg::heap_entry_t      x_q, x_d;
  tarh_pkg::heap_entry_t      ch_q, ch_d;
  tarh_pkg::heap_entry_t      top_q, top_d;
  logic [tarh_pkg::TickW-1:0] tick_q, tick_d;
  logic [tarh_pkg::ProdW-1:0] prod_q, prod_d;
  logic                       started_q, started_d;
  logic [tarh_pkg::IdW-1:0]   sid_q, sid_d;
  logic                       rej_q, rej_d;
  logic                       out_vld_q, out_vld_d;
  logic [tarh_pkg::OutDataW-1:0] out_q, out_d;

  // Heap RAM
  tarh_pkg::heap_entry_t      mem_q [HEAP_CAPACITY];
  tarh_pkg::heap_entry_t      rdata_q;
  logic [AddrW-1:0]           rd_addr;
  logic                       we;
  logic [AddrW-1:0]           wr_addr;
  tarh_pkg::heap_entry_t      wdata;

  // Shared decode
  logic             accept;
  logic             id_ok;
  logic             full;
  logic [SlotW-1:0] count_ext;
  logic [SlotW-1:0] k_dbl;
  logic             due;
  logic             out_free;
  logic [CntW+4:0]  count_wide;

  assign s_axis_tready_o = (state_q == tarh_pkg::ST_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign id_ok     = {4'b0, in_id} < tarh_pkg::TaskCntW'(tarh_pkg::TASK_COUNT);
  assign full      = count_q >= CntW'(HEAP_CAPACITY);
  assign count_ext = SlotW'(count_q);
  assign k_dbl     = k_q << 1;
  assign due       = tarh_pkg::CmpW'(tick_q) >= tarh_pkg::CmpW'(prod_q);
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign count_wide = {5'b0, count_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tarh_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == tarh_pkg::OP_ADD) begin
            if (id_ok && in_arr != '0 && !full) begin
              state_d = tarh_pkg::ST_UP_RD;
            end else begin
              state_d = tarh_pkg::ST_DONE;
            end
          end else if (count_q != '0) begin
            state_d = tarh_pkg::ST_TK_MUL;
          end else begin
            state_d = tarh_pkg::ST_DONE;
          end
        end
      end
      tarh_pkg::ST_UP_RD: begin
        state_d = (k_q == SlotW'(1)) ? tarh_pkg::ST_WR_FIN : tarh_pkg::ST_UP_CMP;
      end
      tarh_pkg::ST_UP_CMP: begin
        state_d = (x_q.arr < rdata_q.arr) ? tarh_pkg::ST_UP_RD : tarh_pkg::ST_WR_FIN;
      end
      tarh_pkg::ST_TK_MUL: state_d = tarh_pkg::ST_TK_CMP;
      tarh_pkg::ST_TK_CMP: begin
        state_d = due ? tarh_pkg::ST_TK_LAST : tarh_pkg::ST_DONE;
      end
      tarh_pkg::ST_TK_LAST: state_d = tarh_pkg::ST_DN_RDL;
      tarh_pkg::ST_DN_RDL: begin
        state_d = (k_dbl > count_ext) ? tarh_pkg::ST_WR_FIN : tarh_pkg::ST_DN_RDR;
      end
      tarh_pkg::ST_DN_RDR: begin
        state_d = (k_dbl < count_ext) ? tarh_pkg::ST_DN_SEL : tarh_pkg::ST_DN_CMP;
      end
      tarh_pkg::ST_DN_SEL: state_d = tarh_pkg::ST_DN_CMP;
      tarh_pkg::ST_DN_CMP: begin
        state_d = (x_q.arr < ch_q.arr) ? tarh_pkg::ST_WR_FIN : tarh_pkg::ST_DN_RDL;
      end
      tarh_pkg::ST_WR_FIN: state_d = tarh_pkg::ST_DONE;
      tarh_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tarh_pkg::ST_IDLE;
        end
      end
      default: state_d = tarh_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_d   = count_q;
    k_d       = k_q;
    j_d       = j_q;
    x_d       = x_q;
    ch_d      = ch_q;
    top_d     = top_q;
    tick_d    = tick_q;
    prod_d    = prod_q;
    started_d = started_q;
    sid_d     = sid_q;
    rej_d     = rej_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = AddrW'(k_q - SlotW'(1));
    wdata     = x_q;

    // Result leaves the output register
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      tarh_pkg::ST_IDLE: begin
        // slot 1 is read here so a tick sees the top next cycle
        rd_addr = '0;
        if (accept) begin
          started_d = 1'b0;
          sid_d     = '0;
          rej_d     = 1'b0;
          x_d.arr   = in_arr;
          x_d.id    = in_id;
          tick_d    = in_tick;
          if (in_op == tarh_pkg::OP_ADD && id_ok) begin
            if (in_arr == '0) begin
              started_d = 1'b1;
              sid_d     = in_id;
            end else if (full) begin
              rej_d = 1'b1;
            end else begin
              count_d = count_q + CntW'(1);
              k_d     = count_ext + SlotW'(1);
            end
          end
        end
      end
      tarh_pkg::ST_UP_RD: begin
        rd_addr = AddrW'((k_q >> 1) - SlotW'(1));
      end
      tarh_pkg::ST_UP_CMP: begin
        // parent moves down into the hole
        if (x_q.arr < rdata_q.arr) begin
          we    = 1'b1;
          wdata = rdata_q;
          k_d   = k_q >> 1;
        end
      end
      tarh_pkg::ST_TK_MUL: begin
        top_d  = rdata_q;
        prod_d = tarh_pkg::ProdW'(rdata_q.arr) *
                 tarh_pkg::ProdW'(tarh_pkg::TICKS_PER_UNIT);
      end
      tarh_pkg::ST_TK_CMP: begin
        // fetch the last entry
        rd_addr = AddrW'(count_ext - SlotW'(1));
        if (due) begin
          started_d = 1'b1;
          sid_d     = top_q.id;
          count_d   = count_q - CntW'(1);
        end
      end
      tarh_pkg::ST_TK_LAST: begin
        x_d = rdata_q;
        k_d = SlotW'(1);
      end
      tarh_pkg::ST_DN_RDL: begin
        rd_addr = AddrW'(k_dbl - SlotW'(1));
      end
      tarh_pkg::ST_DN_RDR: begin
        rd_addr = AddrW'(k_dbl);
        ch_d    = rdata_q;
        j_d     = k_dbl;
      end
      tarh_pkg::ST_DN_SEL: begin
        // right child only when strictly earlier
        if (ch_q.arr > rdata_q.arr) begin
          ch_d = rdata_q;
          j_d  = j_q + SlotW'(1);
        end
      end
      tarh_pkg::ST_DN_CMP: begin
        if (!(x_q.arr < ch_q.arr)) begin
          we    = 1'b1;
          wdata = ch_q;
          k_d   = j_q;
        end
      end
      tarh_pkg::ST_WR_FIN: begin
        we    = 1'b1;
        wdata = x_q;
      end
      tarh_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = {4'b0, count_wide[4:0], rej_q, sid_q, started_q};
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tarh_pkg::ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    j_q       <= j_d;
    x_q       <= x_d;
    ch_q      <= ch_d;
    top_q     <= top_d;
    tick_q    <= tick_d;
    prod_q    <= prod_d;
    started_q <= started_d;
    sid_q     <= sid_d;
    rej_q     <= rej_d;
    out_q     <= out_d;
  end

  // Heap RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

endmodule
